>>> hw/rtl/multi_waveform_phase_oscillator_macros.svh
// Assertion macros for the oscillator RTL.
// No dependencies; include with the bare file name inside a module body.
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_MACROS_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MWPO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mwpo assertion failed");

// Next-cycle implication, checked out of reset.
`define MWPO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mwpo assertion failed");

`endif

>>> hw/rtl/mwpo_pkg.sv
// Shared widths, waveform codes, stage types and the quarter-wave sine table
// for the multi-waveform phase oscillator. No dependencies.
package mwpo_pkg;

    localparam int NUM_VOICES       = 8;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int VOICE_W  = 3;
    localparam int FREQ_W   = 22;
    localparam int ACT_W    = 2;
    localparam int TICK_W   = 24;
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int IN_DATA_W = 32;
    localparam int VIDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int QIDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W   = FREQ_W + TICK_W;
    localparam int SINE_IDX_SHIFT = $clog2(SINE_TABLE_DEPTH);

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(97392);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [ACT_W-1:0] WAVE_SINE   = 2'd0;
    localparam logic [ACT_W-1:0] WAVE_SQUARE = 2'd1;
    localparam logic [ACT_W-1:0] WAVE_SAW    = 2'd2;

    typedef logic [SAMPLE_W-1:0] qsine_t [0:SINE_TABLE_DEPTH];

    // Request handed from the phase stage to the waveform stage.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [ACT_W-1:0]   action;
        logic               live;     // voice was in range, phase advanced
    } wave_req_t;

    // Quotient of two non-negative values by shift and subtract.
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // round(32768 * sin(pi/2 * k / D)) by an integer Taylor series in Q30.
    function automatic qsine_t build_qsine();
        qsine_t          tbl;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          r;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) >> SINE_IDX_SHIFT;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 5; n++) begin
                term = (term * x2) >> 30;
                term = udiv(term, 64'((2 * n) * (2 * n + 1)));
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum * 32768 + (longint'(1) << 29)) >>> 30;
            if (r > 32768) begin
                r = 32768;
            end
            tbl[k] = SAMPLE_W'(r);
        end
        return tbl;
    endfunction

    localparam qsine_t QSINE = build_qsine();

endpackage

>>> hw/rtl/mwpo_phase.sv
// Input register, increment multiply and per-voice phase accumulators.
// Depends on mwpo_pkg and multi_waveform_phase_oscillator_macros.svh.
module mwpo_phase (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mwpo_pkg::TICK_W-1:0]   tick_period,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mwpo_pkg::VOICE_W-1:0]  in_voice,
    input  logic [mwpo_pkg::FREQ_W-1:0]   in_freq,
    input  logic [mwpo_pkg::ACT_W-1:0]    in_action,
    output logic                          req_valid,
    input  logic                          req_ready,
    output mwpo_pkg::wave_req_t           req
);
    import mwpo_pkg::*;

    // Stage 1: captured request
    logic                v1_reg;
    logic [VOICE_W-1:0]  voice1_reg;
    logic [FREQ_W-1:0]   freq1_reg;
    logic [ACT_W-1:0]    act1_reg;
    // Stage 2: phase increment
    logic                v2_reg;
    logic [VOICE_W-1:0]  voice2_reg;
    logic [ACT_W-1:0]    act2_reg;
    logic [PHASE_W-1:0]  inc2_reg;
    // Stage 3: new phase
    logic                v3_reg;
    wave_req_t           req3_reg;

    logic [PHASE_W-1:0]  phase_store_reg [NUM_VOICES];

    logic                rdy1;
    logic                rdy2;
    logic                rdy3;
    logic [PROD_W-1:0]   prod;
    logic [VIDX_W-1:0]   vidx2;
    logic                live2;
    logic [PHASE_W-1:0]  phase_next;

    assign rdy3     = !v3_reg || req_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign prod       = PROD_W'(freq1_reg) * PROD_W'(tick_period);
    assign vidx2      = VIDX_W'(voice2_reg);
    assign live2      = int'(voice2_reg) < NUM_VOICES;
    assign phase_next = phase_store_reg[vidx2] + inc2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            voice1_reg <= in_voice;
            freq1_reg  <= in_freq;
            act1_reg   <= in_action;
        end
        if (rdy2 && v1_reg) begin
            voice2_reg <= voice1_reg;
            act2_reg   <= act1_reg;
            inc2_reg   <= prod[8 +: PHASE_W];
        end
        if (rdy3 && v2_reg) begin
            req3_reg.phase  <= phase_next;
            req3_reg.action <= act2_reg;
            req3_reg.live   <= live2;
        end
    end

    // Read-add-write in the same cycle: the same voice may follow in the next cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                phase_store_reg[i] <= '0;
            end
        end else if (rdy3 && v2_reg && live2) begin
            phase_store_reg[vidx2] <= phase_next;
        end
    end

    assign req_valid = v3_reg;
    assign req       = req3_reg;

    `include "multi_waveform_phase_oscillator_macros.svh"

    `MWPO_ASSERT_NEXT(a_store_follows, aclk, aresetn, rdy3 && v2_reg && live2, phase_store_reg[$past(vidx2)] == req3_reg.phase)
    `MWPO_ASSERT_NEXT(a_stage3_hold, aclk, aresetn, v3_reg && !req_ready, v3_reg && $stable(req3_reg))
    `MWPO_ASSERT_IMPL(a_stall_means_full, aclk, aresetn, !in_ready, v1_reg && v2_reg && v3_reg)

endmodule

>>> hw/rtl/mwpo_wave.sv
// Waveform shaping (sine table, square, saw) and the result register.
// Depends on mwpo_pkg.
module mwpo_wave (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  mwpo_pkg::wave_req_t            req,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mwpo_pkg::SAMPLE_W-1:0]  out_sample
);
    import mwpo_pkg::*;

    logic                   valid_reg;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic [SAMPLE_W-1:0]    sample_next;

    logic [1:0]             quad;
    logic [PHASE_W+QIDX_W-3:0] frac_prod;
    logic [QIDX_W-1:0]      idx;
    logic [QIDX_W-1:0]      tidx;
    logic [SAMPLE_W-1:0]    mag;
    logic [SAMPLE_W:0]      sine_sum;
    logic [SAMPLE_W-1:0]    sine_val;

    assign quad      = req.phase[PHASE_W-1 -: 2];
    assign frac_prod = (PHASE_W+QIDX_W-2)'(req.phase[PHASE_W-3:0])
                     * (PHASE_W+QIDX_W-2)'(SINE_TABLE_DEPTH);
    assign idx       = frac_prod[PHASE_W-2 +: QIDX_W];
    // Odd quadrants walk the table backwards
    assign tidx      = quad[0] ? (QIDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
    assign mag       = QSINE[tidx];

    always_comb begin
        if (quad[1]) begin
            sine_sum = (SAMPLE_W+1)'(32768) - (SAMPLE_W+1)'(mag);
        end else begin
            sine_sum = (SAMPLE_W+1)'(32768) + (SAMPLE_W+1)'(mag);
        end
        sine_val = sine_sum[SAMPLE_W] ? '1 : sine_sum[SAMPLE_W-1:0];
    end

    always_comb begin
        sample_next = '0;
        if (req.live) begin
            case (req.action)
                WAVE_SINE:   sample_next = sine_val;
                WAVE_SQUARE: sample_next = req.phase[PHASE_W-1] ? '1 : '0;
                WAVE_SAW:    sample_next = req.phase[PHASE_W-1 -: SAMPLE_W];
                default:     sample_next = '0;
            endcase
        end
    end

    assign req_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (req_ready) begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_ready && req_valid) begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;

endmodule

>>> hw/rtl/multi_waveform_phase_oscillator.sv
// Top level of the multi-waveform phase oscillator bank.
// Depends on mwpo_pkg, mwpo_phase and mwpo_wave.
//
// Bank of eight phase-accumulator oscillators. Each request names a voice, a
// frequency (unsigned Q14.8 Hz) and a waveform (sine, square, saw). The voice's
// 32-bit phase advances by (freq_hz * tick_period) >> 8 modulo one cycle, and
// one unsigned Q0.16 sample of the new phase comes back per request, in order.
// Sine is (1+sin)/2 from a 257-entry quarter-wave table, no interpolation;
// square is 0 below half phase and 65535 above; saw is the top 16 phase bits.
// An unused waveform code still advances the phase and returns 0. Throughput
// is one request per cycle while m_tready does not stall the output, including
// back-to-back requests to the same voice, since each voice's phase is read,
// added and written back in the same cycle. From s_ acceptance to m_tvalid a
// request passes the input register, which loads at the accepting edge, then
// the increment multiply, phase accumulate, and waveform with result register.
// tick_period resets to 97392 (about 2^32/44100) and is rewritten through
// cfg_wr_en/cfg_wr_data; write it only while no request is in flight.
// Phase accumulators reset to zero.
module multi_waveform_phase_oscillator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: tick_period, unsigned Q0.32 seconds per tick
    input  logic                             cfg_wr_en,
    input  logic [mwpo_pkg::TICK_W-1:0]      cfg_wr_data,
    // Request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mwpo_pkg::IN_DATA_W-1:0]   s_tdata,   // [2:0] voice, [24:3] freq_hz, rest 0
    input  logic [mwpo_pkg::ACT_W-1:0]       s_tuser,   // [1:0] action
    // Sample channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mwpo_pkg::SAMPLE_W-1:0]    m_tdata    // [15:0] sample
);
    import mwpo_pkg::*;

    logic [TICK_W-1:0] tick_reg;
    logic              req_valid;
    logic              req_ready;
    wave_req_t         req;

    // Hold the tick period; take a new value on every write strobe.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= TICK_RESET;
        end else if (cfg_wr_en) begin
            tick_reg <= cfg_wr_data;
        end
    end

    // Advance the addressed voice's phase.
    mwpo_phase u_phase (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_period (tick_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_voice    (s_tdata[VOICE_W-1:0]),
        .in_freq     (s_tdata[VOICE_W +: FREQ_W]),
        .in_action   (s_tuser),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req)
    );

    // Shape the new phase into a sample and hold it until taken.
    mwpo_wave u_wave (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (m_tdata)
    );

endmodule

>>> tb/sv/mwpo_sample_checker.sv
// Sample checker for the multi-waveform phase oscillator testbench: watches the
// config, request and sample channels, predicts every sample and compares.
// Depends on mwpo_pkg for widths, sizes and waveform codes.
module mwpo_sample_checker
    import mwpo_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [TICK_W-1:0]    cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,    // [2:0] voice, [24:3] freq_hz, rest 0
    input  logic [ACT_W-1:0]     s_tuser,    // [1:0] action
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [SAMPLE_W-1:0]  m_tdata,    // [15:0] sample
    output int                   error_count,
    output int                   samples_outstanding,
    output int                   samples_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // pi/2 in Q30
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;

    typedef struct {
        logic [SAMPLE_W-1:0] want;
        logic [VOICE_W-1:0]  voice;
        logic [ACT_W-1:0]    wave;
        int                  req_no;
    } sample_pred_t;

    logic [SAMPLE_W-1:0] quarter_wave [0:SINE_TABLE_DEPTH];
    logic [PHASE_W-1:0]  voice_phase [NUM_VOICES];
    logic [TICK_W-1:0]   tick_period;
    sample_pred_t        pending_samples [$];
    int                  req_seen   = 0;
    int                  mismatches = 0;
    int                  checked    = 0;

    // round(32768 * sin(pi/2 * k / depth)), integer Taylor series through x^11
    function automatic logic [SAMPLE_W-1:0] quarter_wave_entry(input int k);
        longint ang;
        longint ang_sq;
        longint term;
        longint acc;
        longint rounded;
        ang    = (QUARTER_TURN_Q30 * longint'(k)) / longint'(SINE_TABLE_DEPTH);
        ang_sq = (ang * ang) >>> 30;
        term   = ang;
        acc    = ang;
        for (int n = 1; n <= 5; n++) begin
            term = (term * ang_sq) >>> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - term : acc + term;
        end
        if (acc < 0) acc = 0;
        rounded = (acc * 32768 + (longint'(1) <<< 29)) >>> 30;
        if (rounded > 32768) rounded = 32768;
        return SAMPLE_W'(rounded);
    endfunction

    function automatic logic [SAMPLE_W-1:0] wave_level(input logic [PHASE_W-1:0] ph,
                                                       input logic [ACT_W-1:0]   wave);
        int unsigned idx;
        logic [16:0] mag;
        logic [16:0] level;
        case (wave)
            WAVE_SINE: begin
                idx = int'((longint'(ph[29:0]) * SINE_TABLE_DEPTH) >>> 30);
                // odd quadrants run the table backwards, upper half is below midscale
                mag = {1'b0, ph[30] ? quarter_wave[SINE_TABLE_DEPTH - idx] : quarter_wave[idx]};
                level = ph[31] ? 17'd32768 - mag : 17'd32768 + mag;
                return (level > 17'd65535) ? 16'hFFFF : level[15:0];
            end
            WAVE_SQUARE: return ph[31] ? 16'hFFFF : 16'h0000;
            WAVE_SAW:    return ph[31:16];
            default:     return '0;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] sample check: %s", $realtime, what);
        mismatches++;
    endtask

    initial begin
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) quarter_wave[k] = quarter_wave_entry(k);
    end

    always @(posedge aclk) begin
        logic [VOICE_W-1:0] voice;
        logic [FREQ_W-1:0]  freq;
        logic [PROD_W-1:0]  prod;
        sample_pred_t       pred;
        if (!aresetn) begin
            foreach (voice_phase[i]) voice_phase[i] = '0;
            tick_period = TICK_RESET;
        end else begin
            if (cfg_wr_en) tick_period = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                voice       = s_tdata[VOICE_W-1:0];
                freq        = s_tdata[VOICE_W +: FREQ_W];
                pred.voice  = voice;
                pred.wave   = s_tuser;
                pred.req_no = req_seen;
                pred.want   = '0;
                if (voice < NUM_VOICES) begin
                    prod = freq * tick_period;
                    voice_phase[voice] = voice_phase[voice] + prod[PHASE_W+7:8];
                    pred.want = wave_level(voice_phase[voice], s_tuser);
                end
                pending_samples.push_back(pred);
                req_seen++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch($sformatf("sample %0d with no request outstanding",
                                              m_tdata));
                end else begin
                    pred = pending_samples.pop_front();
                    checked++;
                    if (m_tdata !== pred.want)
                        report_mismatch($sformatf("request %0d voice %0d wave %0d: got %0d, want %0d",
                                                  pred.req_no, pred.voice, pred.wave,
                                                  m_tdata, pred.want));
                end
            end
        end
        error_count         <= mismatches;
        samples_outstanding <= pending_samples.size();
        samples_checked     <= checked;
    end

endmodule

>>> tb/sv/multi_waveform_phase_oscillator_tb.sv
// Top of the multi-waveform phase oscillator testbench: clock, reset, request
// stimulus, sample back-pressure, watchdog and verdict.
// Depends on mwpo_pkg, multi_waveform_phase_oscillator and mwpo_sample_checker.
module multi_waveform_phase_oscillator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mwpo_pkg::*;

    // Waveform code the block does not define; it still advances the phase.
    localparam logic [ACT_W-1:0]  WAVE_UNUSED      = 2'd3;
    localparam logic [FREQ_W-1:0] FREQ_MAX         = '1;
    localparam logic [TICK_W-1:0] TICK_MAX         = '1;
    localparam int                RANDOM_PER_PHASE = 207;
    localparam int                IDLE_LIMIT       = 1000;
    localparam int                DRAIN_CYCLES     = 8;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PATTERN} ready_mode_e;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [TICK_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata     = '0;     // [2:0] voice, [24:3] freq_hz, rest 0
    logic [ACT_W-1:0]     s_tuser     = '0;     // [1:0] action
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [SAMPLE_W-1:0]  m_tdata;              // [15:0] sample

    int error_count;
    int samples_outstanding;
    int samples_checked;
    int requests_sent = 0;
    int settings_used = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;

    logic [TICK_W-1:0] tick_plan [6];

    multi_waveform_phase_oscillator u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    mwpo_sample_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .error_count         (error_count),
        .samples_outstanding (samples_outstanding),
        .samples_checked     (samples_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Present one request and hold it until the block takes it. Bursts of
    // random length are separated by random gaps; some gaps are zero so that
    // bursts run together. Valid stays high between back-to-back requests.
    task automatic send_request(input logic [VOICE_W-1:0] voice,
                                input logic [FREQ_W-1:0]  freq,
                                input logic [ACT_W-1:0]   wave);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(48, 128)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({freq, voice});
        s_tuser  <= wave;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Drop valid and hold until every predicted sample has come back.
    task automatic wait_samples_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (samples_outstanding != 0);
    endtask

    task automatic write_tick(input logic [TICK_W-1:0] period);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= period;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // Mostly mid-range and full-range values, with zero and full scale
    // appearing often enough to matter.
    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FREQ_MAX;
            2, 3, 4: return FREQ_W'($urandom);
            default: return FREQ_W'($urandom & ((32'd1 << $urandom_range(1, FREQ_W)) - 1));
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_wave();
        int r;
        r = $urandom_range(0, 15);
        if (r == 15) return WAVE_UNUSED;
        case (r % 3)
            0:       return WAVE_SINE;
            1:       return WAVE_SQUARE;
            default: return WAVE_SAW;
        endcase
    endfunction

    // Most runs sweep one voice at a fixed frequency so its phase walks through
    // whole cycles and wraps; the rest are scattered single requests.
    task automatic run_random(input int count);
        int                 left;
        int                 run_len;
        bit                 sweep;
        bit                 fixed_wave;
        logic [VOICE_W-1:0] voice;
        logic [FREQ_W-1:0]  freq;
        logic [ACT_W-1:0]   wave;
        left = count;
        while (left > 0) begin
            sweep      = ($urandom_range(0, 4) != 0);
            fixed_wave = 1'($urandom_range(0, 1));
            run_len    = sweep ? $urandom_range(4, 40) : $urandom_range(1, 10);
            if (run_len > left) run_len = left;
            voice = VOICE_W'($urandom_range(0, NUM_VOICES - 1));
            freq  = pick_freq();
            wave  = pick_wave();
            repeat (run_len) begin
                if (!sweep) begin
                    voice = VOICE_W'($urandom_range(0, NUM_VOICES - 1));
                    freq  = pick_freq();
                end
                if (!sweep || !fixed_wave) wave = pick_wave();
                send_request(voice, freq, wave);
            end
            left -= run_len;
        end
    endtask

    // Sample back-pressure: switch at random among always ready, coin toss,
    // mostly stalled and a fixed repeating on/off pattern.
    always @(posedge aclk) begin
        ready_mode_e ready_mode;
        int          mode_left;
        int          pattern_cnt;
        if (!aresetn) begin
            m_tready    <= 1'b0;
            mode_left   = 0;
            pattern_cnt = 0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = ready_mode_e'($urandom_range(0, 3));
                mode_left  = $urandom_range(64, 256);
            end
            mode_left--;
            pattern_cnt++;
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:      m_tready <= ((pattern_cnt % 7) < 4);
            endcase
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request or sample moved for %0d cycles", IDLE_LIMIT);
            $display("multi_waveform_phase_oscillator_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tick_plan = '{TICK_MAX, TICK_W'(1), TICK_W'(0),
                      TICK_W'($urandom_range(1, TICK_MAX)),
                      TICK_W'($urandom_range(20000, 200000)), TICK_RESET};

        // Directed part, at the reset tick_period, every voice starting at zero.
        settings_used = 1;
        send_request(0, '0, WAVE_SINE);          // zero phase: midscale
        send_request(0, '0, WAVE_SQUARE);
        send_request(0, '0, WAVE_SAW);
        send_request(0, '0, WAVE_UNUSED);        // undefined waveform returns 0
        // This step lands just past a quarter turn: sine peaks and saturates,
        // then the same step visits half, three quarters and wraps.
        send_request(6, 22'd2822400, WAVE_SINE);
        send_request(6, 22'd2822400, WAVE_SQUARE);
        send_request(6, 22'd2822400, WAVE_SAW);
        send_request(6, 22'd2822400, WAVE_SINE);  // just past the wrap: midscale
        send_request(6, 22'd2822400, WAVE_UNUSED);
        send_request(6, 22'd2822400, WAVE_SAW);   // after the wrap
        send_request(7, FREQ_MAX, WAVE_SINE);
        send_request(7, FREQ_MAX, WAVE_SQUARE);
        send_request(7, FREQ_MAX, WAVE_SAW);
        send_request(7, FREQ_MAX, WAVE_UNUSED);
        send_request(1, FREQ_MAX, WAVE_SAW);
        send_request(2, 22'h200000, WAVE_SQUARE);
        send_request(3, 22'h155555, WAVE_SINE);
        send_request(4, 22'h2AAAAA, WAVE_SAW);
        send_request(5, 22'd1, WAVE_SINE);
        send_request(5, 22'd1, WAVE_SAW);
        send_request(7, '0, WAVE_SAW);           // zero step holds the phase

        run_random(RANDOM_PER_PHASE);

        // Rewrite tick_period only with nothing in flight: full scale, the
        // minimum, zero (phase frozen), random values, then the reset value.
        foreach (tick_plan[p]) begin
            wait_samples_drained();
            write_tick(tick_plan[p]);
            run_random(RANDOM_PER_PHASE);
        end

        wait_samples_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests over %0d tick_period settings (full scale, minimum, zero, random)",
                 requests_sent, settings_used);
        $display("%0d samples compared, %0d mismatches", samples_checked, error_count);
        if (error_count == 0) begin
            $display("multi_waveform_phase_oscillator_tb: done, clean");
        end else begin
            $display("multi_waveform_phase_oscillator_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/mwpo_pkg.sv
hw/rtl/mwpo_phase.sv
hw/rtl/mwpo_wave.sv
hw/rtl/multi_waveform_phase_oscillator.sv
tb/sv/mwpo_sample_checker.sv
tb/sv/multi_waveform_phase_oscillator_tb.sv
